// File: src/tdpt_pkg.sv
`timescale 1ns / 1ps

package tdpt_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // Smallest trial divisor
    localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// File: src/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Sequence: zero and one go straight to the result as not prime; otherwise each trial divisor
//   from 2 upward takes a check step and then a bit-serial remainder pass over all NUMBER_WIDTH
//   bits, until an exact divisor is found or the divisor's square exceeds the candidate (prime).
// Throughput: one transaction at a time; s_ready is low from acceptance until the result is
//   loaded into the output register. The bit-serial remainder loop, and any stall on m_ready, set the rate.
// Reset: synchronous, active-low aresetn; sequencer returns to idle, m_valid clears.

module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 31
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NUMBER_WIDTH-1:0] s_candidate,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_prime_flag
);

    // Divisor never exceeds floor(sqrt(2^W - 1)) + 1
    localparam int DW = (NUMBER_WIDTH + 1) / 2 + 1;
    // Running square d*d; stops at the first square above the candidate, or earlier at an exact divisor
    localparam int SW = NUMBER_WIDTH + 1;
    localparam int CW = (NUMBER_WIDTH > 2) ? $clog2(NUMBER_WIDTH) : 1;

    tdpt_pkg::state_t state_reg, state_next;

    logic [NUMBER_WIDTH-1:0] number_reg,  number_next;   // candidate under test
    logic [NUMBER_WIDTH-1:0] shift_reg,   shift_next;    // dividend bits, MSB first
    logic [DW-1:0]           divisor_reg, divisor_next;
    logic [SW-1:0]           square_reg,  square_next;   // divisor_reg squared
    logic [DW-1:0]           rem_reg,     rem_next;      // partial remainder, < divisor
    logic [CW-1:0]           bit_cnt_reg, bit_cnt_next;
    logic                    flag_reg,    flag_next;     // pending verdict
    logic                    m_valid_reg, m_valid_next;
    logic                    m_flag_reg,  m_flag_next;

    // Restoring-division step
    logic [DW:0]   trial;
    logic [DW:0]   trial_diff;
    logic [DW-1:0] rem_step;

    assign trial      = {rem_reg, shift_reg[NUMBER_WIDTH-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    // trial < 2 * divisor, so the top bit of the difference is the borrow
    assign rem_step   = trial_diff[DW] ? trial[DW-1:0] : trial_diff[DW-1:0];

    assign s_ready      = (state_reg == tdpt_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_prime_flag = m_flag_reg;

    always_comb begin
        state_next   = state_reg;
        number_next  = number_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        square_next  = square_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg;
        m_flag_next  = m_flag_reg;

        // Output register drains independently of the sequencer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    number_next  = s_candidate;
                    divisor_next = DW'(tdpt_pkg::FIRST_DIVISOR);
                    square_next  = SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
                    // zero and one are not prime
                    if (s_candidate < NUMBER_WIDTH'(tdpt_pkg::FIRST_DIVISOR)) begin
                        flag_next  = 1'b0;
                        state_next = tdpt_pkg::ST_DONE;
                    end else begin
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (square_reg > {1'b0, number_reg}) begin
                    flag_next  = 1'b1;           // no divisor up to sqrt
                    state_next = tdpt_pkg::ST_DONE;
                end else begin
                    shift_next   = number_reg;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = tdpt_pkg::ST_DIVIDE;
                end
            end
            tdpt_pkg::ST_DIVIDE: begin
                rem_next     = rem_step;
                shift_next   = {shift_reg[NUMBER_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CW'(NUMBER_WIDTH - 1)) begin
                    if (rem_step == '0) begin
                        flag_next  = 1'b0;       // exact divisor found
                        state_next = tdpt_pkg::ST_DONE;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        square_next  = square_reg + SW'({divisor_reg, 1'b1});
                        divisor_next = divisor_reg + DW'(1);
                        state_next   = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = flag_reg;
                    state_next   = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge aclk) begin
        number_reg  <= number_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        square_reg  <= square_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        flag_reg    <= flag_next;
        m_flag_reg  <= m_flag_next;
    end

endmodule

// File: src/tdpt_checker.sv
`timescale 1ns / 1ps

module tdpt_checker #(
    parameter int NUMBER_WIDTH = 31
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [NUMBER_WIDTH-1:0] s_candidate,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_prime_flag
);

    // Reset leaves the block idle with no pending result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

    // One transaction at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after acceptance");

    // Zero and one resolve immediately as not prime
    a_small_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid &&
         (s_candidate == NUMBER_WIDTH'(0) || s_candidate == NUMBER_WIDTH'(1)))
        |=> ##1 (m_valid && !m_prime_flag))
        else $error("zero or one not reported as not prime");

    // A new result appears only as the block becomes ready again
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while still busy");

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_prime_flag)))
        else $error("result changed while stalled");

endmodule

bind trial_division_prime_test tdpt_checker #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
) u_tdpt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_candidate (s_candidate),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_prime_flag(m_prime_flag)
);
